@@ sv/ffc_pkg.sv @@
// ffc_pkg: shared widths, weights, register indexes and types of the
// rgb565 frame contrast check. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffc_pkg;

	localparam int GRAY_W = 8;
	localparam int SUM_W  = 28;
	localparam int CNT_W  = 21;
	localparam int PROD_W = 24;
	localparam int LOW_W  = 7;
	localparam int STEP_W = 8;
	localparam int CFG_IW = 8;
	localparam int CFG_DW = 8;

	localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(1048576);

	// q0.16 luma weights
	localparam logic [15:0] W_BLUE  = 16'd7471;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_RED   = 16'd19589;

	localparam logic [CFG_IW-1:0] REG_MEAN_FLOOR  = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_MARGIN_STEP = CFG_IW'(1);

	localparam logic [LOW_W-1:0]  MEAN_FLOOR_RST  = LOW_W'(20);
	localparam logic [STEP_W-1:0] MARGIN_STEP_RST = STEP_W'(25);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]  count;
		logic [GRAY_W-1:0] min;
		logic [GRAY_W-1:0] max;
	} frame_t;

	typedef struct packed {
		logic [LOW_W-1:0]  mean_floor;
		logic [STEP_W-1:0] margin_step;
	} cfg_t;

endpackage
`default_nettype wire

@@ sv/rgb565_frame_contrast_check_unit.sv @@
// rgb565_frame_contrast_check_unit: top level with configuration registers.
// depends on ffc_pkg, ffc_front, ffc_fifo and ffc_back.
// The unit takes one rgb565 pixel per cycle while full is low and gives one
// request on the result side per frame, on the pixel marked last: accepted,
// mean, min and max gray. Gray conversion is a two-stage pipeline ahead of the
// statistics registers; each finished frame is queued (4 entries) for the back
// end, which divides sum by count with one quotient bit per cycle and holds the
// result in its output register until it is popped. Full rises only when the
// frame queue, counting frames still in the pipeline, is full, which happens
// when frames arrive faster than the back end divides them or when results are
// not taken.
// Configuration writes are taken at once (ready is always high) and should be
// made while no frame is in progress.
`timescale 1ns / 1ps
`default_nettype none
module rgb565_frame_contrast_check_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [15:0]                  pixel,
	input  wire logic                         last,
	output logic                              empty,
	input  wire logic                         pop,
	output logic                              accepted,
	output logic [ffc_pkg::GRAY_W-1:0]        mean_gray,
	output logic [ffc_pkg::GRAY_W-1:0]        min_gray,
	output logic [ffc_pkg::GRAY_W-1:0]        max_gray,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [ffc_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [ffc_pkg::CFG_DW-1:0]   cfg_data
);

	ffc_pkg::cfg_t                   cfg_q;
	ffc_pkg::frame_t                 q_din, q_dout;
	logic                            q_push, q_pop, q_empty;
	logic [ffc_pkg::FIFO_CW-1:0]     q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_floor  <= ffc_pkg::MEAN_FLOOR_RST;
			cfg_q.margin_step <= ffc_pkg::MARGIN_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ffc_pkg::REG_MEAN_FLOOR: begin
					cfg_q.mean_floor <= cfg_data[ffc_pkg::LOW_W-1:0];
				end
				ffc_pkg::REG_MARGIN_STEP: begin
					cfg_q.margin_step <= cfg_data[ffc_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ffc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.last    (last),
		.q_count (q_count),
		.q_push  (q_push),
		.q_din   (q_din)
	);

	ffc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty),
		.count  (q_count)
	);

	ffc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_dout    (q_dout),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.accepted  (accepted),
		.mean_gray (mean_gray),
		.min_gray  (min_gray),
		.max_gray  (max_gray)
	);

endmodule
`default_nettype wire

@@ sv/ffc_front.sv @@
// ffc_front: pixel intake, gray conversion pipeline and per-frame statistics.
// depends on ffc_pkg; pushes one frame_t record per frame into ffc_fifo.
`timescale 1ns / 1ps
`default_nettype none
module ffc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [15:0]                pixel,
	input  wire logic                       last,
	input  wire logic [ffc_pkg::FIFO_CW-1:0] q_count,
	output logic                            q_push,
	output ffc_pkg::frame_t                 q_din
);

	logic                           take;
	logic [7:0]                     red8, green8, blue8;
	logic                           vld_s1, last_s1;
	logic [ffc_pkg::PROD_W-1:0]     prod_r_s1, prod_g_s1, prod_b_s1;
	logic [ffc_pkg::PROD_W:0]       wsum;
	logic                           vld_s2, last_s2;
	logic [ffc_pkg::GRAY_W-1:0]     gray_s2;
	logic [ffc_pkg::GRAY_W-1:0]     min_q, max_q, min_n, max_n;
	logic [ffc_pkg::SUM_W-1:0]      sum_q, sum_n;
	logic [ffc_pkg::CNT_W-1:0]      cnt_q, cnt_n;
	logic                           room;
	logic [ffc_pkg::FIFO_CW:0]      occupancy;

	// frames in flight must always have a queue slot
	assign occupancy = {1'b0, q_count} + {{ffc_pkg::FIFO_CW{1'b0}}, vld_s1 & last_s1}
		+ {{ffc_pkg::FIFO_CW{1'b0}}, vld_s2 & last_s2};
	assign full = occupancy >= (ffc_pkg::FIFO_CW + 1)'(ffc_pkg::FIFO_DEPTH);
	assign take = push & ~full;

	assign red8   = {pixel[15:11], 3'b000};
	assign green8 = {pixel[10:5], 2'b00};
	assign blue8  = {pixel[4:0], 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1   <= last;
		prod_r_s1 <= ffc_pkg::W_RED * red8;
		prod_g_s1 <= ffc_pkg::W_GREEN * green8;
		prod_b_s1 <= ffc_pkg::W_BLUE * blue8;
		last_s2   <= last_s1;
		gray_s2   <= wsum[23:16];
	end

	assign wsum = {1'b0, prod_b_s1} + {1'b0, prod_g_s1} + {1'b0, prod_r_s1};

	// pixels past the frame limit leave the statistics alone
	always_comb begin
		room  = cnt_q < ffc_pkg::MAX_PIXELS;
		min_n = (room && gray_s2 < min_q) ? gray_s2 : min_q;
		max_n = (room && gray_s2 > max_q) ? gray_s2 : max_q;
		sum_n = room ? sum_q + {{(ffc_pkg::SUM_W - ffc_pkg::GRAY_W){1'b0}}, gray_s2} : sum_q;
		cnt_n = room ? cnt_q + 1'b1 : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			max_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (vld_s2) begin
			if (last_s2) begin
				min_q <= '1;
				max_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				min_q <= min_n;
				max_q <= max_n;
				sum_q <= sum_n;
				cnt_q <= cnt_n;
			end
		end
	end

	assign q_push      = vld_s2 & last_s2;
	assign q_din.sum   = sum_n;
	assign q_din.count = cnt_n;
	assign q_din.min   = min_n;
	assign q_din.max   = max_n;

`ifndef SYNTHESIS
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (min_q <= max_q))
		else $error("running min above running max");
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ffc_pkg::MAX_PIXELS)
		else $error("pixel count beyond frame limit");
`endif

endmodule
`default_nettype wire

@@ sv/ffc_fifo.sv @@
// ffc_fifo: short queue of frame statistics between front and back.
// depends on ffc_pkg for depth and the frame_t record.
`timescale 1ns / 1ps
`default_nettype none
module ffc_fifo (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire ffc_pkg::frame_t             din,
	input  wire logic                        pop,
	output ffc_pkg::frame_t                  dout,
	output logic                             empty,
	output logic [ffc_pkg::FIFO_CW-1:0]      count
);

	ffc_pkg::frame_t                 mem [ffc_pkg::FIFO_DEPTH];
	logic [ffc_pkg::FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [ffc_pkg::FIFO_CW-1:0]     cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign dout  = mem[rd_ptr_q];
	assign empty = cnt_q == '0;
	assign count = cnt_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != ffc_pkg::FIFO_CW'(ffc_pkg::FIFO_DEPTH) || pop))
		else $error("frame queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("frame queue underflow");
`endif

endmodule
`default_nettype wire

@@ sv/ffc_back.sv @@
// ffc_back: per-frame mean by shift-subtract division and the contrast decision.
// depends on ffc_pkg; takes frame records from ffc_fifo, holds one result.
`timescale 1ns / 1ps
`default_nettype none
module ffc_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ffc_pkg::cfg_t               cfg,
	input  wire logic                        q_empty,
	input  wire ffc_pkg::frame_t             q_dout,
	output logic                             q_pop,
	input  wire logic                        pop,
	output logic                             empty,
	output logic                             accepted,
	output logic [ffc_pkg::GRAY_W-1:0]       mean_gray,
	output logic [ffc_pkg::GRAY_W-1:0]       min_gray,
	output logic [ffc_pkg::GRAY_W-1:0]       max_gray
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                      st_q;
	logic [ffc_pkg::SUM_W-1:0]       rem_q;
	logic [ffc_pkg::CNT_W-1:0]       div_q;
	logic [ffc_pkg::GRAY_W-1:0]      quo_q, min_q, max_q;
	logic [2:0]                      idx_q;
	logic [ffc_pkg::SUM_W:0]         shifted, diff;
	logic                            ovld_q, acc_q;
	logic [ffc_pkg::GRAY_W-1:0]      mean_q, omin_q, omax_q;
	logic [ffc_pkg::GRAY_W-1:0]      mean, low8, hi_lim, step_lim, thmin, thmax;
	logic                            ok, load;

	// mean never exceeds 255, so eight quotient bits suffice
	assign shifted = (ffc_pkg::SUM_W + 1)'(div_q) << idx_q;
	assign diff    = {1'b0, rem_q} - shifted;
	assign q_pop   = (st_q == ST_IDLE) && !q_empty;

	always_comb begin
		mean     = (div_q == '0) ? '0 : quo_q;
		low8     = {1'b0, cfg.mean_floor};
		hi_lim   = 8'd255 - low8;
		step_lim = 8'd255 - cfg.margin_step;
		thmin    = (mean > cfg.margin_step) ? mean - cfg.margin_step : '0;
		thmax    = (mean < step_lim) ? mean + cfg.margin_step : 8'd255;
		ok       = (div_q != '0) && (mean > low8) && (mean < hi_lim)
			&& (min_q < thmin) && (max_q > thmax);
	end

	assign load = (st_q == ST_DONE) && (!ovld_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (idx_q == '0) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_q <= q_dout.sum;
			div_q <= q_dout.count;
			min_q <= q_dout.min;
			max_q <= q_dout.max;
			quo_q <= '0;
			idx_q <= 3'd7;
		end else if (st_q == ST_DIV) begin
			if (!diff[ffc_pkg::SUM_W]) begin
				rem_q        <= diff[ffc_pkg::SUM_W-1:0];
				quo_q[idx_q] <= 1'b1;
			end
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load) begin
			ovld_q <= 1'b1;
		end else if (pop) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q  <= ok;
			mean_q <= mean;
			omin_q <= min_q;
			omax_q <= max_q;
		end
	end

	assign empty     = !ovld_q;
	assign accepted  = acc_q;
	assign mean_gray = mean_q;
	assign min_gray  = omin_q;
	assign max_gray  = omax_q;

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && div_q != '0)
			|-> (rem_q < {{(ffc_pkg::SUM_W - ffc_pkg::CNT_W){1'b0}}, div_q}))
		else $error("division remainder not below divisor");
	a_accept_spread: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && acc_q) |-> (omin_q < mean_q && omax_q > mean_q))
		else $error("accepted frame without spread around mean");
`endif

endmodule
`default_nettype wire

@@ tb/sv/rgb565_frame_contrast_check_unit_test.sv @@
// rgb565_frame_contrast_check_unit_test: self-checking bench for the frame contrast unit.
// Drives pixel frames and register writes, predicts each frame verdict and checks the results.
// depends on ffc_pkg and rgb565_frame_contrast_check_unit.
`timescale 1ns / 1ps
module rgb565_frame_contrast_check_unit_test;

	localparam logic [31:0] LUMA_WB = 32'd7471;
	localparam logic [31:0] LUMA_WG = 32'd38470;
	localparam logic [31:0] LUMA_WR = 32'd19589;
	localparam logic [ffc_pkg::CNT_W-1:0] FRAME_PIXEL_CAP = ffc_pkg::CNT_W'(1048576);
	localparam logic [ffc_pkg::CFG_IW-1:0] REG_SPARE = ffc_pkg::CFG_IW'(2);
	localparam logic [ffc_pkg::CFG_IW-1:0] REG_TOP   = '1;
	localparam int DRAIN_CYCLES = 30;
	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_PIXELS = 125;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
	typedef enum int {NOISE, NEAR_FLAT, TWO_TONE, FLAT} frame_shape_e;

	typedef struct packed {
		logic [15:0] px;
		logic        lst;
	} pixel_req_t;

	typedef struct packed {
		logic                       accepted;
		logic [ffc_pkg::GRAY_W-1:0] mean;
		logic [ffc_pkg::GRAY_W-1:0] darkest;
		logic [ffc_pkg::GRAY_W-1:0] brightest;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [15:0] pixel = '0;
	logic last = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [ffc_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [ffc_pkg::CFG_DW-1:0] cfg_data = '0;
	logic full, empty, accepted, cfg_ready;
	logic [ffc_pkg::GRAY_W-1:0] mean_gray, min_gray, max_gray;

	pixel_req_t pixel_reqs[$];
	verdict_t   verdicts_due[$];

	// predictor state
	logic [ffc_pkg::LOW_W-1:0]  cfg_low = ffc_pkg::MEAN_FLOOR_RST;
	logic [ffc_pkg::STEP_W-1:0] cfg_step = ffc_pkg::MARGIN_STEP_RST;
	logic [ffc_pkg::GRAY_W-1:0] run_min = '1;
	logic [ffc_pkg::GRAY_W-1:0] run_max = '0;
	logic [ffc_pkg::SUM_W-1:0]  run_sum = '0;
	logic [ffc_pkg::CNT_W-1:0]  run_count = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	bit pix_taken = 1'b0;
	int errors = 0;
	int frames_seen = 0;
	int frames_passed = 0;
	int pixels_taken = 0;
	int reg_writes = 0;
	int cycles = 0;

	rgb565_frame_contrast_check_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .pixel(pixel), .last(last),
		.empty(empty), .pop(pop),
		.accepted(accepted), .mean_gray(mean_gray), .min_gray(min_gray), .max_gray(max_gray),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ffc_pkg::GRAY_W-1:0] luma(input logic [15:0] px);
		logic [31:0] weighted;
		weighted = LUMA_WB * {24'd0, px[4:0], 3'd0}
			+ LUMA_WG * {24'd0, px[10:5], 2'd0}
			+ LUMA_WR * {24'd0, px[15:11], 3'd0};
		return weighted[23:16];
	endfunction

	task automatic absorb_pixel(input logic [15:0] px, input logic lst);
		logic [ffc_pkg::GRAY_W-1:0] g;
		int unsigned m, low, step, lo_bound, hi_bound;
		verdict_t v;
		if (run_count < FRAME_PIXEL_CAP) begin
			g = luma(px);
			if (g < run_min) run_min = g;
			if (g > run_max) run_max = g;
			run_sum = run_sum + ffc_pkg::SUM_W'(g);
			run_count = run_count + 1'b1;
		end
		if (lst) begin
			m = (run_count != 0) ? (32'(run_sum) / 32'(run_count)) & 32'hFF : 0;
			low = cfg_low;
			step = cfg_step;
			v.accepted = 1'b0;
			if (run_count != 0 && m > low && m < 255 - low) begin
				lo_bound = (m > step) ? m - step : 0;
				hi_bound = (m < 255 - step) ? m + step : 255;
				v.accepted = (run_min < lo_bound) && (run_max > hi_bound);
			end
			v.mean = m[7:0];
			v.darkest = run_min;
			v.brightest = run_max;
			verdicts_due.push_back(v);
			run_min = '1;
			run_max = '0;
			run_sum = '0;
			run_count = '0;
		end
	endtask

	// monitor: requests taken on both sides
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n) begin
			pix_taken = push && !full;
			if (pix_taken) begin
				pixels_taken++;
				absorb_pixel(pixel, last);
			end
			if (pop && !empty) begin
				frames_seen++;
				if (verdicts_due.size() == 0) begin
					$error("result with no frame pending: accepted %0b mean %0d min %0d max %0d",
						accepted, mean_gray, min_gray, max_gray);
					errors++;
				end else begin
					exp_v = verdicts_due.pop_front();
					if (exp_v.accepted) frames_passed++;
					if (accepted !== exp_v.accepted) begin
						$error("accepted: expected %0b, got %0b", exp_v.accepted, accepted);
						errors++;
					end
					if (mean_gray !== exp_v.mean) begin
						$error("mean_gray: expected %0d, got %0d", exp_v.mean, mean_gray);
						errors++;
					end
					if (min_gray !== exp_v.darkest) begin
						$error("min_gray: expected %0d, got %0d", exp_v.darkest, min_gray);
						errors++;
					end
					if (max_gray !== exp_v.brightest) begin
						$error("max_gray: expected %0d, got %0d", exp_v.brightest, max_gray);
						errors++;
					end
				end
			end
		end
	end

	// driver
	always @(negedge clk) begin
		pixel_req_t nxt;
		if (arst_n) begin
			pop <= ($urandom_range(99) >= stall_pct);
			if (!push || pix_taken) begin
				if (pixel_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pixel_reqs.pop_front();
					push <= 1'b1;
					pixel <= nxt.px;
					last <= nxt.lst;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic queue_pixel(input logic [15:0] px, input logic lst);
		while (pixel_reqs.size() > 256) @(negedge clk);
		pixel_reqs.push_back('{px: px, lst: lst});
	endtask

	task automatic drain();
		do @(posedge clk); while (pixel_reqs.size() != 0 || push || verdicts_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ffc_pkg::CFG_IW-1:0] idx,
			input logic [ffc_pkg::CFG_DW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ffc_pkg::REG_MEAN_FLOOR) cfg_low = val[ffc_pkg::LOW_W-1:0];
		else if (idx == ffc_pkg::REG_MARGIN_STEP) cfg_step = val;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin idle_pct = 0; stall_pct = 0; end
			IDLE_SENDER: begin idle_pct = 68; stall_pct = 0; end
			IDLE_RECEIVER: begin idle_pct = 0; stall_pct = 68; end
			default: begin idle_pct = 15; stall_pct = 15; end
		endcase
	endtask

	task automatic queue_random_frame(output int len);
		int r;
		frame_shape_e shape;
		logic [15:0] base, px;
		r = $urandom_range(0, 99);
		if (r < 70) len = $urandom_range(1, 8);
		else if (r < 95) len = $urandom_range(9, 30);
		else len = $urandom_range(31, 80);
		shape = frame_shape_e'($urandom_range(0, 3));
		base = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			case (shape)
				NOISE: px = 16'($urandom);
				NEAR_FLAT: px = base ^ (16'($urandom) & 16'h18C3);
				TWO_TONE: px = $urandom_range(0, 1)
					? {5'($urandom_range(24, 31)), 6'($urandom_range(48, 63)),
						5'($urandom_range(24, 31))}
					: {5'($urandom_range(0, 7)), 6'($urandom_range(0, 15)),
						5'($urandom_range(0, 7))};
				default: px = base;
			endcase
			queue_pixel(px, i == len - 1);
		end
	endtask

	task automatic run_phase(input idle_mode_e mode, input logic [ffc_pkg::LOW_W-1:0] low_val,
			input logic [ffc_pkg::STEP_W-1:0] step_val);
		int sent, len;
		drain();
		write_reg(ffc_pkg::REG_MEAN_FLOOR, {1'($urandom_range(0, 1)), low_val});
		write_reg(ffc_pkg::REG_MARGIN_STEP, step_val);
		set_idling(mode);
		sent = 0;
		while (sent < PHASE_PIXELS) begin
			queue_random_frame(len);
			sent += len;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames at reset register values
		queue_pixel(16'h0000, 1'b1);
		queue_pixel(16'hFFFF, 1'b1);
		queue_pixel(16'hF800, 1'b1);
		queue_pixel(16'h07E0, 1'b1);
		queue_pixel(16'h001F, 1'b1);
		queue_pixel(16'h0000, 1'b0);
		queue_pixel(16'hFFFF, 1'b1);
		repeat (3) queue_pixel(16'h8410, 1'b0);
		queue_pixel(16'h8410, 1'b1);
		queue_pixel(16'h0000, 1'b0);
		queue_pixel(16'h8410, 1'b0);
		queue_pixel(16'hFFFF, 1'b1);
		queue_pixel(16'h0000, 1'b0);
		queue_pixel(16'h0000, 1'b0);
		queue_pixel(16'hFFFF, 1'b0);
		queue_pixel(16'hFFFF, 1'b1);
		queue_pixel(16'h5555, 1'b0);
		queue_pixel(16'hAAAA, 1'b1);

		// writes to unused indexes must leave the registers alone
		drain();
		write_reg(REG_SPARE, 8'hA5);
		write_reg(REG_TOP, 8'h5A);
		set_idling(IDLE_NONE);
		repeat (4) queue_pixel(16'($urandom), 1'b0);
		queue_pixel(16'($urandom), 1'b1);

		run_phase(IDLE_NONE, 7'd0, 8'd0);
		run_phase(IDLE_SENDER, 7'd127, 8'd255);
		run_phase(IDLE_RECEIVER, 7'd127, 8'd0);
		run_phase(IDLE_BOTH, 7'd0, 8'd255);
		for (int p = 0; p < 4; p++)
			run_phase(idle_mode_e'(p), 7'($urandom_range(0, 60)), 8'($urandom_range(0, 80)));

		drain();
		$display("covered %0d pixels in %0d frames (%0d accepted) over %0d register writes,",
			pixels_taken, frames_seen, frames_passed, reg_writes);
		$display("with four idle/stall mixes and extreme thresholds");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
